[sv/cpt_pkg.sv]
// Shared types and constants for the closest-point-on-triangle block.
// Used by the result channel interface and by the top level; depends on nothing.
`default_nettype none
package cpt_pkg;

  localparam int REGION_W = 3;

  // Voronoi region that holds the closest point, in the order of the tests.
  typedef enum logic [REGION_W-1:0] {
    REGION_A  = 3'd0,
    REGION_B  = 3'd1,
    REGION_C  = 3'd2,
    REGION_AB = 3'd3,
    REGION_AC = 3'd4,
    REGION_BC = 3'd5,
    REGION_IN = 3'd6
  } region_t;

  // Number of pipeline stages that each wide multiplication is spread over.
  localparam int V_CHUNKS = 4;
  localparam int N_CHUNKS = 4;

endpackage
`default_nettype wire

[sv/cpt_query_if.sv]
// Input channel of the closest-point block: query point and triangle vertices.
// Depends on nothing.
`default_nettype none
interface cpt_query_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] query_x;
  logic signed [COORD_WIDTH-1:0] query_y;
  logic signed [COORD_WIDTH-1:0] query_z;
  logic signed [COORD_WIDTH-1:0] vert_a_x;
  logic signed [COORD_WIDTH-1:0] vert_a_y;
  logic signed [COORD_WIDTH-1:0] vert_a_z;
  logic signed [COORD_WIDTH-1:0] vert_b_x;
  logic signed [COORD_WIDTH-1:0] vert_b_y;
  logic signed [COORD_WIDTH-1:0] vert_b_z;
  logic signed [COORD_WIDTH-1:0] vert_c_x;
  logic signed [COORD_WIDTH-1:0] vert_c_y;
  logic signed [COORD_WIDTH-1:0] vert_c_z;

  modport source (
    output valid, query_x, query_y, query_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    input  ready
  );
  modport sink (
    input  valid, query_x, query_y, query_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    output ready
  );
endinterface
`default_nettype wire

[sv/cpt_result_if.sv]
// Output channel of the closest-point block: closest point, region, flag.
// Depends on cpt_pkg for the region code width.
`default_nettype none
interface cpt_result_if #(
  parameter int COORD_WIDTH = 32
);
  logic                            valid;
  logic                            ready;
  logic signed [COORD_WIDTH-1:0]   near_x;
  logic signed [COORD_WIDTH-1:0]   near_y;
  logic signed [COORD_WIDTH-1:0]   near_z;
  logic [cpt_pkg::REGION_W-1:0]    region;
  logic                            degenerate;

  modport source (
    output valid, near_x, near_y, near_z, region, degenerate,
    input  ready
  );
  modport sink (
    input  valid, near_x, near_y, near_z, region, degenerate,
    output ready
  );
endinterface
`default_nettype wire

[sv/cpt_div_pipe.sv]
// Pipelined exact divider with round-to-nearest (ties up): quo = floor(num/den + 1/2).
// One quotient bit per stage, then an output register. Standalone, no package use.
`default_nettype none
module cpt_div_pipe #(
  parameter int NW  = 171,
  parameter int DEW = 139,
  parameter int QB  = 34,
  parameter int OW  = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [DEW-1:0] den,
  output logic [OW-1:0]        quo
);

  localparam int TW = NW + 3;
  localparam int RW = (TW > DEW + 2 + QB) ? TW : DEW + 2 + QB;

  logic signed [NW:0]  n1;
  logic signed [DEW:0] d1;
  logic signed [TW-1:0] t2;
  logic [DEW+1:0]      dd2;

  logic [RW-1:0]   rem [0:QB];
  logic [QB-1:0]   qv  [0:QB];
  logic            ng  [0:QB];
  logic [DEW+1:0]  dvs [0:QB];

  logic            nz;
  logic [QB-1:0]   qfix;

  // Make the divisor positive, then form 2n + d over 2d.
  always_ff @(posedge clk) begin
    if (en) begin
      if (den[DEW-1]) begin
        n1 <= -((NW+1)'(num));
        d1 <= -((DEW+1)'(den));
      end else begin
        n1 <= (NW+1)'(num);
        d1 <= (DEW+1)'(den);
      end
      t2  <= (TW'(n1) <<< 1) + TW'(d1);
      dd2 <= (DEW+2)'(d1) << 1;
      ng[0]  <= t2[TW-1];
      rem[0] <= t2[TW-1] ? RW'(-t2) : RW'(t2);
      qv[0]  <= '0;
      dvs[0] <= dd2;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = RW'(dvs[j]) << (QB - 1 - j);
    assign ge = rem[j] >= sh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= ge ? rem[j] - sh : rem[j];
        qv[j+1]  <= qv[j] | (QB'(ge) << (QB - 1 - j));
        ng[j+1]  <= ng[j];
        dvs[j+1] <= dvs[j];
      end
    end
  end

  // A negative dividend needs the ceiling of the magnitude, then negation.
  assign nz   = |rem[QB];
  assign qfix = ng[QB] ? (~qv[QB] + QB'(!nz)) : qv[QB];

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= qfix[OW-1:0];
    end
  end

endmodule
`default_nettype wire

[sv/closest_point_on_triangle.sv]
// Top level of the closest-point-on-triangle pipeline.
// Depends on cpt_pkg, cpt_query_if, cpt_result_if and cpt_div_pipe.
`default_nettype none
// This block takes a query point and a triangle (all coordinates signed fixed
// point, COORD_WIDTH bits) and returns the closest point on the triangle, the
// Voronoi region it lies in, and a degenerate flag. All arithmetic is exact, so
// the number of fraction bits does not matter; edge and interior points are
// rounded once, to nearest with ties toward plus infinity. When the divisor of
// the chosen edge or interior region is zero, vertex a is returned with the
// degenerate flag set. The block is a fully pipelined datapath that accepts one
// transaction per clock cycle. The pipeline depth is set by the exact rounding
// divider, which resolves one quotient bit per stage, plus the wide products
// that are spread over four stages each. A two-entry output buffer lets the
// pipeline keep accepting queries while one result waits to be taken; the
// whole pipeline holds only when that buffer is full.
module closest_point_on_triangle #(
  parameter int COORD_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  cpt_query_if.sink    query,
  cpt_result_if.source result
);

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;           // coordinate differences
  localparam int PPW  = 2 * DW;          // one product of differences
  localparam int PW   = PPW + 2;         // dot products d1..d6
  localparam int PVW  = 2 * PW;          // product of two dot products
  localparam int VW   = PVW + 1;         // va, vb, vc
  localparam int DEW  = VW + 2;          // divisor
  localparam int NW   = VW + DW + 1;     // numerator
  localparam int QB   = W + 2;           // quotient bits
  localparam int DL   = QB + 4;          // divider latency

  localparam int NCV  = cpt_pkg::V_CHUNKS;
  localparam int CHV  = PW / NCV + 1;
  localparam int VPW  = NCV * CHV;
  localparam int NCN  = cpt_pkg::N_CHUNKS;
  localparam int CHN  = VW / NCN + 1;
  localparam int NPW  = NCN * CHN;

  // Stage numbers: register stage s is loaded from stage s - 1.
  localparam int SV = 3 + NCV;   // va/vb/vc products complete
  localparam int SA = SV + 1;    // va, vb, vc
  localparam int SB = SV + 2;    // region and interior divisor
  localparam int SC = SV + 3;    // operand selection
  localparam int SN = SC + NCN;  // numerators complete
  localparam int SQ = SN + DL;   // quotients complete

  // Operand pairs of the six products: vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6,
  // va = d3*d6 - d5*d4.
  localparam int VA_IDX [6] = '{0, 2, 4, 0, 2, 4};
  localparam int VB_IDX [6] = '{3, 1, 1, 5, 5, 3};

  typedef struct packed {
    logic [2:0][DW-1:0] ab;
    logic [2:0][DW-1:0] ac;
    logic [2:0][DW-1:0] bc;
    logic [2:0][W-1:0]  a;
    logic [2:0][W-1:0]  b;
    logic [2:0][W-1:0]  c;
  } geo_t;

  typedef struct packed {
    logic          f_a;
    logic          f_b;
    logic          f_c;
    logic          t_ab;
    logic          t_ac;
    logic [PW:0]   e1;
    logic [PW:0]   e2;
    logic [PW:0]   den_ab;
    logic [PW:0]   den_ac;
    logic [PW+1:0] den_bc;
    logic [PW-1:0] d1;
    logic [PW-1:0] d2;
  } mid_t;

  typedef struct packed {
    logic [VW-1:0] va;
    logic [VW-1:0] vb;
    logic [VW-1:0] vc;
  } vx_t;

  typedef struct packed {
    logic [2:0][W-1:0] base;
    cpt_pkg::region_t  region;
    logic              degen;
    logic              skip;
  } tail_t;

  typedef struct packed {
    logic [VW-1:0]      m1;
    logic [VW-1:0]      m2;
    logic [2:0][DW-1:0] x1;
    logic [2:0][DW-1:0] x2;
    logic [DEW-1:0]     den;
    tail_t              tl;
  } sel_t;

  typedef struct packed {
    logic [2:0][W-1:0] near;
    cpt_pkg::region_t  region;
    logic              degen;
  } out_t;

  // Pipeline control. Everything advances together unless the output buffer
  // is full; valid bits travel alongside the data.
  logic          adv;
  logic          in_fire;
  logic [SQ:1]   vld;
  logic [1:0]    cnt;
  logic          push;
  logic          pop;

  assign adv     = (cnt != 2'd2);
  assign in_fire = query.valid && adv;
  assign query.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[SQ-1:1], in_fire};
    end
  end

  // Stage 1: coordinate differences.
  logic signed [W-1:0] pin [3];
  logic signed [W-1:0] ain [3];
  logic signed [W-1:0] bin [3];
  logic signed [W-1:0] cin [3];
  geo_t                geo_in;
  geo_t                geo [1:SB];
  logic [DW-1:0]       ap1 [3];
  logic [DW-1:0]       bp1 [3];
  logic [DW-1:0]       cp1 [3];

  always_comb begin
    pin[0] = query.query_x;  pin[1] = query.query_y;  pin[2] = query.query_z;
    ain[0] = query.vert_a_x; ain[1] = query.vert_a_y; ain[2] = query.vert_a_z;
    bin[0] = query.vert_b_x; bin[1] = query.vert_b_y; bin[2] = query.vert_b_z;
    cin[0] = query.vert_c_x; cin[1] = query.vert_c_y; cin[2] = query.vert_c_z;
    for (int i = 0; i < 3; i++) begin
      geo_in.ab[i] = DW'(bin[i]) - DW'(ain[i]);
      geo_in.ac[i] = DW'(cin[i]) - DW'(ain[i]);
      geo_in.bc[i] = DW'(cin[i]) - DW'(bin[i]);
      geo_in.a[i]  = ain[i];
      geo_in.b[i]  = bin[i];
      geo_in.c[i]  = cin[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo[1] <= geo_in;
      for (int i = 0; i < 3; i++) begin
        ap1[i] <= DW'(pin[i]) - DW'(ain[i]);
        bp1[i] <= DW'(pin[i]) - DW'(bin[i]);
        cp1[i] <= DW'(pin[i]) - DW'(cin[i]);
      end
    end
  end

  for (genvar s = 2; s <= SB; s++) begin : g_geo
    always_ff @(posedge clk) begin
      if (adv) begin
        geo[s] <= geo[s-1];
      end
    end
  end

  // Stage 2: the eighteen component products of the six dot products.
  // Even dots use ab, odd ones ac; pairs use ap, bp and cp in turn.
  logic [PPW-1:0] prod2 [6][3];

  for (genvar j = 0; j < 6; j++) begin : g_dot
    for (genvar i = 0; i < 3; i++) begin : g_cmp
      logic signed [DW-1:0] sl;
      logic signed [DW-1:0] sr;
      if (j % 2 == 0) begin : g_ab
        assign sl = geo[1].ab[i];
      end else begin : g_ac
        assign sl = geo[1].ac[i];
      end
      if (j / 2 == 0) begin : g_ap
        assign sr = ap1[i];
      end else if (j / 2 == 1) begin : g_bp
        assign sr = bp1[i];
      end else begin : g_cp
        assign sr = cp1[i];
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          prod2[j][i] <= sl * sr;
        end
      end
    end
  end

  // Stage 3: dot products d1..d6 (index 0..5), then held while the products
  // of pairs of them are accumulated.
  logic [PW-1:0] dd [3:SV-1][6];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 6; j++) begin
        dd[3][j] <= PW'($signed(prod2[j][0])) + PW'($signed(prod2[j][1]))
                  + PW'($signed(prod2[j][2]));
      end
    end
  end

  for (genvar s = 4; s <= SV - 1; s++) begin : g_dd
    always_ff @(posedge clk) begin
      if (adv) begin
        dd[s] <= dd[s-1];
      end
    end
  end

  // Stage 4: region tests that need only the dot products, and the edge
  // divisors.
  logic signed [PW-1:0] sd [6];
  mid_t                 mid_in;
  mid_t                 mid [4:SB];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      sd[j] = dd[3][j];
    end
    mid_in.f_a    = (sd[0] <= 0) && (sd[1] <= 0);
    mid_in.f_b    = (sd[2] >= 0) && (sd[3] <= sd[2]);
    mid_in.f_c    = (sd[5] >= 0) && (sd[4] <= sd[5]);
    mid_in.t_ab   = (sd[0] >= 0) && (sd[2] <= 0);
    mid_in.t_ac   = (sd[1] >= 0) && (sd[5] <= 0);
    mid_in.e1     = (PW+1)'(sd[3]) - (PW+1)'(sd[2]);
    mid_in.e2     = (PW+1)'(sd[4]) - (PW+1)'(sd[5]);
    mid_in.den_ab = (PW+1)'(sd[0]) - (PW+1)'(sd[2]);
    mid_in.den_ac = (PW+1)'(sd[1]) - (PW+1)'(sd[5]);
    mid_in.den_bc = (PW+2)'(sd[3]) - (PW+2)'(sd[2]) + (PW+2)'(sd[4]) - (PW+2)'(sd[5]);
    mid_in.d1     = sd[0];
    mid_in.d2     = sd[1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid[4] <= mid_in;
    end
  end

  for (genvar s = 5; s <= SB; s++) begin : g_mid
    always_ff @(posedge clk) begin
      if (adv) begin
        mid[s] <= mid[s-1];
      end
    end
  end

  // Stages 4..SV: six products of dot products, one chunk of the second
  // operand per stage.
  logic [PVW-1:0] pacc [4:SV][6];

  for (genvar k = 0; k < NCV; k++) begin : g_vch
    for (genvar j = 0; j < 6; j++) begin : g_vp
      logic signed [PW-1:0]    opa;
      logic signed [PW-1:0]    opb;
      logic [VPW-1:0]          bext;
      logic signed [CHV:0]     ch;
      logic signed [PW+CHV:0]  part;
      logic signed [PVW-1:0]   addend;
      assign opa  = dd[3+k][VA_IDX[j]];
      assign opb  = dd[3+k][VB_IDX[j]];
      assign bext = VPW'(opb);
      if (k == NCV - 1) begin : g_top
        assign ch = (CHV+1)'($signed(bext[k*CHV +: CHV]));
      end else begin : g_low
        assign ch = $signed({1'b0, bext[k*CHV +: CHV]});
      end
      assign part   = opa * ch;
      assign addend = PVW'(part) <<< (k * CHV);
      if (k == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (adv) begin
            pacc[4][j] <= addend;
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (adv) begin
            pacc[4+k][j] <= pacc[3+k][j] + addend;
          end
        end
      end
    end
  end

  // Stage SA: the three cross terms.
  vx_t vx [SA:SB];

  always_ff @(posedge clk) begin
    if (adv) begin
      vx[SA].vc <= VW'($signed(pacc[SV][0])) - VW'($signed(pacc[SV][1]));
      vx[SA].vb <= VW'($signed(pacc[SV][2])) - VW'($signed(pacc[SV][3]));
      vx[SA].va <= VW'($signed(pacc[SV][4])) - VW'($signed(pacc[SV][5]));
      vx[SB]    <= vx[SA];
    end
  end

  // Stage SB: pick the first region whose test passes, and form the
  // interior divisor.
  cpt_pkg::region_t     rg_next;
  cpt_pkg::region_t     rg;
  logic [DEW-1:0]       den6;
  logic                 le_va;
  logic                 le_vb;
  logic                 le_vc;
  logic                 t_bc;

  assign le_va = vx[SA].va[VW-1] || (vx[SA].va == '0);
  assign le_vb = vx[SA].vb[VW-1] || (vx[SA].vb == '0);
  assign le_vc = vx[SA].vc[VW-1] || (vx[SA].vc == '0);
  assign t_bc  = !mid[SA].e1[PW] && !mid[SA].e2[PW];

  always_comb begin
    if (mid[SA].f_a) begin
      rg_next = cpt_pkg::REGION_A;
    end else if (mid[SA].f_b) begin
      rg_next = cpt_pkg::REGION_B;
    end else if (mid[SA].f_c) begin
      rg_next = cpt_pkg::REGION_C;
    end else if (le_vc && mid[SA].t_ab) begin
      rg_next = cpt_pkg::REGION_AB;
    end else if (le_vb && mid[SA].t_ac) begin
      rg_next = cpt_pkg::REGION_AC;
    end else if (le_va && t_bc) begin
      rg_next = cpt_pkg::REGION_BC;
    end else begin
      rg_next = cpt_pkg::REGION_IN;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rg   <= rg_next;
      den6 <= DEW'($signed(vx[SA].va)) + DEW'($signed(vx[SA].vb))
            + DEW'($signed(vx[SA].vc));
    end
  end

  // Stage SC: route the region's coefficients, direction vectors, divisor
  // and base vertex. The numerator is m1 * x1 + m2 * x2 per coordinate.
  sel_t sel_in;
  sel_t sel [SC:SN];

  always_comb begin
    sel_in         = '0;
    sel_in.tl.base = geo[SB].a;
    sel_in.tl.region = rg;
    case (rg)
      cpt_pkg::REGION_A: begin
        sel_in.tl.skip = 1'b1;
      end
      cpt_pkg::REGION_B: begin
        sel_in.tl.base = geo[SB].b;
        sel_in.tl.skip = 1'b1;
      end
      cpt_pkg::REGION_C: begin
        sel_in.tl.base = geo[SB].c;
        sel_in.tl.skip = 1'b1;
      end
      cpt_pkg::REGION_AB: begin
        sel_in.m1  = VW'($signed(mid[SB].d1));
        sel_in.x1  = geo[SB].ab;
        sel_in.den = DEW'($signed(mid[SB].den_ab));
      end
      cpt_pkg::REGION_AC: begin
        sel_in.m1  = VW'($signed(mid[SB].d2));
        sel_in.x1  = geo[SB].ac;
        sel_in.den = DEW'($signed(mid[SB].den_ac));
      end
      cpt_pkg::REGION_BC: begin
        sel_in.m1      = VW'($signed(mid[SB].e1));
        sel_in.x1      = geo[SB].bc;
        sel_in.den     = DEW'($signed(mid[SB].den_bc));
        sel_in.tl.base = geo[SB].b;
      end
      cpt_pkg::REGION_IN: begin
        sel_in.m1  = vx[SB].vb;
        sel_in.m2  = vx[SB].vc;
        sel_in.x1  = geo[SB].ab;
        sel_in.x2  = geo[SB].ac;
        sel_in.den = den6;
      end
      default: begin
        sel_in.tl.skip = 1'b1;
      end
    endcase
    // A zero divisor on an edge or in the interior falls back to vertex a.
    if (!sel_in.tl.skip && (sel_in.den == '0)) begin
      sel_in.tl.degen = 1'b1;
      sel_in.tl.skip  = 1'b1;
      sel_in.tl.base  = geo[SB].a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel[SC] <= sel_in;
    end
  end

  for (genvar s = SC + 1; s <= SN; s++) begin : g_sel
    always_ff @(posedge clk) begin
      if (adv) begin
        sel[s] <= sel[s-1];
      end
    end
  end

  // Stages SC+1..SN: numerators, one chunk of the coefficients per stage.
  logic [NW-1:0] nacc [SC+1:SN][3];

  for (genvar k = 0; k < NCN; k++) begin : g_nch
    for (genvar i = 0; i < 3; i++) begin : g_nc
      logic [NPW-1:0]              m1e;
      logic [NPW-1:0]              m2e;
      logic signed [CHN:0]         c1;
      logic signed [CHN:0]         c2;
      logic signed [DW-1:0]        x1;
      logic signed [DW-1:0]        x2;
      logic signed [CHN+DW:0]      p1;
      logic signed [CHN+DW:0]      p2;
      logic signed [NW-1:0]        addend;
      assign m1e = NPW'($signed(sel[SC+k].m1));
      assign m2e = NPW'($signed(sel[SC+k].m2));
      if (k == NCN - 1) begin : g_top
        assign c1 = (CHN+1)'($signed(m1e[k*CHN +: CHN]));
        assign c2 = (CHN+1)'($signed(m2e[k*CHN +: CHN]));
      end else begin : g_low
        assign c1 = $signed({1'b0, m1e[k*CHN +: CHN]});
        assign c2 = $signed({1'b0, m2e[k*CHN +: CHN]});
      end
      assign x1 = sel[SC+k].x1[i];
      assign x2 = sel[SC+k].x2[i];
      assign p1 = c1 * x1;
      assign p2 = c2 * x2;
      assign addend = (NW'(p1) + NW'(p2)) <<< (k * CHN);
      if (k == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (adv) begin
            nacc[SC+1][i] <= addend;
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (adv) begin
            nacc[SC+1+k][i] <= nacc[SC+k][i] + addend;
          end
        end
      end
    end
  end

  // Dividers, one per coordinate; the tail data keeps pace with them.
  logic [W-1:0] quo [3];
  tail_t        tl [SN+1:SQ];

  for (genvar i = 0; i < 3; i++) begin : g_div
    cpt_div_pipe #(
      .NW  (NW),
      .DEW (DEW),
      .QB  (QB),
      .OW  (W)
    ) u_div (
      .clk (clk),
      .en  (adv),
      .num (nacc[SN][i]),
      .den (sel[SN].den),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tl[SN+1] <= sel[SN].tl;
    end
  end

  for (genvar s = SN + 2; s <= SQ; s++) begin : g_tail
    always_ff @(posedge clk) begin
      if (adv) begin
        tl[s] <= tl[s-1];
      end
    end
  end

  // Final point: base vertex plus the rounded offset, or the vertex itself.
  out_t fin;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fin.near[i] = tl[SQ].skip ? tl[SQ].base[i] : tl[SQ].base[i] + quo[i];
    end
    fin.region = tl[SQ].region;
    fin.degen  = tl[SQ].degen;
  end

  // Two-entry output buffer; ent0 is the head that drives the channel.
  out_t ent0;
  out_t ent1;

  assign push = adv && vld[SQ];
  assign pop  = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push && !pop) begin
      cnt <= cnt + 2'd1;
    end else if (pop && !push) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (cnt == 2'd0) begin
        ent0 <= fin;
      end else begin
        ent1 <= fin;
      end
    end else if (pop && !push) begin
      ent0 <= ent1;
    end else if (push && pop) begin
      if (cnt == 2'd1) begin
        ent0 <= fin;
      end else begin
        ent0 <= ent1;
        ent1 <= fin;
      end
    end
  end

  assign result.valid      = (cnt != 2'd0);
  assign result.near_x     = ent0.near[0];
  assign result.near_y     = ent0.near[1];
  assign result.near_z     = ent0.near[2];
  assign result.region     = ent0.region;
  assign result.degenerate = ent0.degen;

endmodule
`default_nettype wire
